@@ hdl/bsb_pkg.sv @@
// ----------------------------------------------------------------------------
// bsb_pkg: shared types and constants for the B-spline basis evaluator
// Word formats, status codes, sequencer states and the Q1.30 clamp.
// ----------------------------------------------------------------------------
package bsb_pkg;

  localparam int unsigned MAX_DEGREE_DEF = 7;
  localparam int unsigned MAX_KNOTS_DEF  = 64;

  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [32:0] TERM_LIM = 33'h1_0000_0000;

  localparam logic       CMD_WRITE = 1'b0;
  localparam logic       CMD_EVAL  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_DENOM = 2'd2;

  typedef struct packed {
    logic               command;
    logic [5:0]         knot_index;
    logic signed [31:0] knot_value;
    logic signed [31:0] param_value;
    logic [5:0]         span_index;
  } bsb_in_t;

  typedef struct packed {
    logic [30:0] basis_value;
    logic [2:0]  basis_number;
    logic        last;
    logic [1:0]  status;
  } bsb_out_t;

  typedef enum logic [3:0] {
    S_IDLE, S_KRD, S_KLEFT, S_KRIGHT, S_TRD, S_TDEN, S_TMUL, S_TDINIT,
    S_TDIV, S_TDONE, S_STEPEND, S_OLOAD, S_OWAIT
  } bsb_state_e;

  // Saturates a signed sum to the range [0, 1.0] in Q1.30.
  function automatic logic [30:0] clamp_q30(logic signed [34:0] v);
    logic [30:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed({4'b0, ONE_Q30})) begin
      r = ONE_Q30;
    end else begin
      r = v[30:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/bspline_basis_eval_core.sv @@
// ----------------------------------------------------------------------------
// bspline_basis_eval_core: Cox-de Boor B-spline basis function evaluator
// Knot store, triangular recurrence sequencer and one shared serial divider.
// ----------------------------------------------------------------------------
// Usage. Input words arrive on in_valid_i / in_stall_o. A write word (command
// 0) stores one signed Q16.16 knot. An evaluate word (command 1) gives
// degree+1 result words on out_valid_o / out_stall_i, one per basis function,
// the final one marked by last. A span whose knot window leaves the store
// gives one word with status "range". The user must write the degree register
// via cfg_we_i / cfg_data_i only while idle; the block does not enforce it.
//
// Sequencing. Each step d of the recurrence reads its knots in S_KRD, S_KLEFT
// and S_KRIGHT, then works through d terms; each term with a positive
// denominator uses the shared multiplier and the restoring serial divider
// twice each. Result words are loaded one at a time, each after the one
// before is taken. The block takes no new word until the last result is taken.
//
// Reset clears the sequencer and sets the degree to three; the knot store is
// not cleared and must be loaded before use. When the receiver stalls, the
// result word is held unchanged until it is taken.
module bspline_basis_eval_core #(
  parameter int unsigned MAX_DEGREE = bsb_pkg::MAX_DEGREE_DEF,
  parameter int unsigned MAX_KNOTS  = bsb_pkg::MAX_KNOTS_DEF
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [2:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  bsb_pkg::bsb_in_t in_word_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output bsb_pkg::bsb_out_t out_word_o
);
  import bsb_pkg::*;

  localparam int unsigned DW = $clog2(MAX_DEGREE + 1);
  localparam int unsigned KW = $clog2(MAX_KNOTS);
  localparam int unsigned SW = 12;

  bsb_state_e state_q, state_d;

  logic [2:0]  degree_q;
  logic [DW-1:0] p_eff, p_q, d_q, k_q, oc_q;
  logic [5:0]  span_q;
  logic signed [31:0] u_q;
  logic [1:0]  stat_q;

  logic signed [32:0] lft_q [MAX_DEGREE+1];
  logic signed [32:0] rgt_q [MAX_DEGREE+1];
  logic [30:0]        nb_q  [MAX_DEGREE+1];

  logic [31:0] knot_mem [MAX_KNOTS];
  logic [31:0] knot_rd_q;
  logic [KW-1:0] rd_addr;
  logic        knot_we;

  logic signed [32:0] xr_q, xl_q;
  logic [30:0] n_q;
  logic [31:0] den_q;
  logic        sel_q;
  logic [62:0] prod_q;
  logic [32:0] rem_q, quo_q;
  logic [5:0]  cnt_q;
  logic        ovf_q;
  logic signed [33:0] tr_q, saved_q;

  logic        out_valid_q;
  bsb_out_t    out_q;

  logic in_acc, win_bad, den_bad, div_ovf, more_k;
  logic [SW-1:0] span_w;
  logic signed [33:0] den_sum, term;
  logic signed [32:0] knot_s, x_sel, lft_new, rgt_new;
  logic [32:0] mag, trial, qsat;
  logic [30:0] upd_val;

  // Effective degree, saturated to what the arrays can hold.
  assign p_eff = (int'(degree_q) > MAX_DEGREE) ? DW'(MAX_DEGREE) : DW'(degree_q);

  assign in_acc  = in_valid_i && !in_stall_o;
  assign span_w  = SW'(in_word_i.span_index);
  assign win_bad = (span_w + SW'(1) < SW'(p_eff)) ||
                   (span_w + SW'(p_eff) >= SW'(MAX_KNOTS));
  assign knot_we = in_acc && (in_word_i.command == CMD_WRITE) &&
                   (SW'(in_word_i.knot_index) < SW'(MAX_KNOTS));

  assign knot_s  = $signed({knot_rd_q[31], knot_rd_q});
  assign lft_new = $signed({u_q[31], u_q}) - knot_s;
  assign rgt_new = knot_s - $signed({u_q[31], u_q});

  assign den_sum = $signed({xr_q[32], xr_q}) + $signed({xl_q[32], xl_q});
  assign den_bad = den_sum[33] || (den_sum == '0);

  assign x_sel   = sel_q ? xl_q : xr_q;
  assign mag     = x_sel[32] ? 33'(-x_sel) : 33'(x_sel);
  assign div_ovf = {2'b0, prod_q[62:33]} >= den_q;
  assign trial   = {rem_q[31:0], prod_q[cnt_q]};
  assign qsat    = (ovf_q || quo_q > TERM_LIM) ? TERM_LIM : quo_q;
  assign term    = x_sel[32] ? -$signed({1'b0, qsat}) : $signed({1'b0, qsat});
  assign more_k  = (k_q + DW'(1)) < d_q;
  assign upd_val = clamp_q30(35'(saved_q) + 35'(tr_q));

  // Knot store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (knot_we) begin
      knot_mem[KW'(in_word_i.knot_index)] <= in_word_i.knot_value;
    end
    knot_rd_q <= knot_mem[rd_addr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && in_word_i.command == CMD_EVAL) begin
          if (win_bad) begin
            state_d = S_OWAIT;
          end else if (p_eff == '0) begin
            state_d = S_OLOAD;
          end else begin
            state_d = S_KRD;
          end
        end
      end
      S_KRD:     state_d = S_KLEFT;
      S_KLEFT:   state_d = S_KRIGHT;
      S_KRIGHT:  state_d = S_TRD;
      S_TRD:     state_d = S_TDEN;
      S_TDEN: begin
        if (!den_bad) begin
          state_d = S_TMUL;
        end else if (more_k) begin
          state_d = S_TRD;
        end else begin
          state_d = S_STEPEND;
        end
      end
      S_TMUL:    state_d = S_TDINIT;
      S_TDINIT:  state_d = div_ovf ? S_TDONE : S_TDIV;
      S_TDIV:    state_d = (cnt_q == '0) ? S_TDONE : S_TDIV;
      S_TDONE: begin
        if (!sel_q) begin
          state_d = S_TMUL;
        end else if (more_k) begin
          state_d = S_TRD;
        end else begin
          state_d = S_STEPEND;
        end
      end
      S_STEPEND: state_d = (d_q == p_q) ? S_OLOAD : S_KRD;
      S_OLOAD:   state_d = S_OWAIT;
      S_OWAIT: begin
        if (!out_stall_i) begin
          state_d = out_q.last ? S_IDLE : S_OLOAD;
        end
      end
      default:   state_d = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_KLEFT: rd_addr = KW'(SW'(span_q) + SW'(d_q));
      default: rd_addr = KW'(SW'(span_q) + SW'(1) - SW'(d_q));
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      degree_q    <= 3'd3;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        degree_q <= cfg_data_i;
      end
      if (state_q == S_IDLE && state_d == S_OWAIT) begin
        out_valid_q <= 1'b1;
      end else if (state_q == S_OLOAD) begin
        out_valid_q <= 1'b1;
      end else if (state_q == S_OWAIT && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers, no reset needed.
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        p_q    <= p_eff;
        span_q <= in_word_i.span_index;
        u_q    <= in_word_i.param_value;
        stat_q <= ST_OK;
        d_q    <= DW'(1);
        oc_q   <= '0;
        nb_q[0] <= ONE_Q30;
        out_q  <= '{basis_value: '0, basis_number: '0, last: 1'b1, status: ST_RANGE};
      end
      S_KLEFT: lft_q[d_q] <= lft_new;
      S_KRIGHT: begin
        rgt_q[d_q] <= rgt_new;
        k_q        <= '0;
        saved_q    <= '0;
      end
      S_TRD: begin
        xr_q  <= rgt_q[k_q + DW'(1)];
        xl_q  <= lft_q[d_q - k_q];
        n_q   <= nb_q[k_q];
        sel_q <= 1'b0;
      end
      S_TDEN: begin
        den_q <= den_sum[31:0];
        if (den_bad) begin
          stat_q       <= ST_DENOM;
          nb_q[k_q]    <= clamp_q30(35'(saved_q));
          saved_q      <= '0;
          k_q          <= k_q + DW'(1);
        end
      end
      S_TMUL: begin
        prod_q <= 63'(mag * 33'(n_q));
        ovf_q  <= 1'b0;
      end
      S_TDINIT: begin
        // An overflowing dividend skips the divider and saturates the term.
        if (div_ovf) begin
          ovf_q <= 1'b1;
        end
        rem_q <= {3'b0, prod_q[62:33]};
        quo_q <= '0;
        cnt_q <= 6'd32;
      end
      S_TDIV: begin
        if (trial >= {1'b0, den_q}) begin
          rem_q <= trial - {1'b0, den_q};
          quo_q <= {quo_q[31:0], 1'b1};
        end else begin
          rem_q <= trial;
          quo_q <= {quo_q[31:0], 1'b0};
        end
        cnt_q <= cnt_q - 6'd1;
      end
      S_TDONE: begin
        ovf_q <= 1'b0;
        if (!sel_q) begin
          tr_q  <= term;
          sel_q <= 1'b1;
        end else begin
          nb_q[k_q] <= upd_val;
          saved_q   <= term;
          k_q       <= k_q + DW'(1);
        end
      end
      S_STEPEND: begin
        nb_q[d_q] <= clamp_q30(35'(saved_q));
        d_q       <= d_q + DW'(1);
      end
      S_OLOAD: begin
        out_q.basis_value  <= nb_q[oc_q];
        out_q.basis_number <= 3'(oc_q);
        out_q.last         <= (oc_q == p_q);
        out_q.status       <= stat_q;
        oc_q               <= oc_q + DW'(1);
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // The remainder always stays below the divisor while dividing.
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TDIV) |-> (rem_q < {1'b0, den_q}))
    else $error("divider remainder not below divisor");

  // A result is only offered while the sequencer waits on the receiver.
  a_out_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (state_q == S_OWAIT))
    else $error("result valid outside output state");

  // A range error is a single, final, zero-valued word.
  a_range_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.status == ST_RANGE) |->
      (out_word_o.last && out_word_o.basis_value == '0))
    else $error("malformed range error word");

  // The block is busy from acceptance of an evaluation until its last word.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_word_i.command == CMD_EVAL) |=> in_stall_o)
    else $error("block not busy after evaluate word");

endmodule
